@@ hdl/ppr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared types and constants for the Paxos proposer round control block.
// ----------------------------------------------------------------------------
package ppr_pkg;

   // default upper bound on peers answering per round
   localparam int PEERS_MAX_DEF = 8;

   // tally counters saturate at the top of this width
   localparam int CNT_W  = 4;
   localparam int NUM_W  = 31;
   localparam int TRY_W  = 9;

   localparam logic [NUM_W-1:0] NUM_TOP = {NUM_W{1'b1}};

   // event kinds on the request channel
   typedef enum logic [1:0] {
      MODE_SUBMIT  = 2'd0,
      MODE_PROPOSE = 2'd1,
      MODE_ACCEPT  = 2'd2,
      MODE_REPORT  = 2'd3
   } mode_type;

   // result kinds on the response channel
   localparam logic [1:0] KIND_PROPOSE = 2'd0;
   localparam logic [1:0] KIND_ACCEPT  = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   // reply status codes
   localparam logic [1:0] ST_PROMISE = 2'd0;
   localparam logic [1:0] ST_HIGHER  = 2'd1;
   localparam logic [1:0] ST_REJECT  = 2'd1;

   // register indexes
   localparam logic REG_PEER_COUNT  = 1'b0;
   localparam logic REG_RETRY_LIMIT = 1'b1;

   // configuration handed to the round engine
   typedef struct packed {
      logic [3:0] peer_count;
      logic [7:0] retry_limit;
   } cfg_type;

endpackage

@@ hdl/paxos_proposer_round_control.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paxos_proposer_round_control
// Paxos proposer control: counts peer replies per round and issues the next
// propose or accept request, or the finish result of a submit.
// ----------------------------------------------------------------------------
// Result: registered; it appears on rsp in the cycle after the event transfer.
// Throughput: one event per cycle; the round engine's single step logic
//   sets this, and req_tready falls only while a result waits on rsp.
// Reset: synchronous, active high; proposer state and tallies clear, but for
//   the stored values; peer_count and retry_limit return to 3. No clearing pass.
// ----------------------------------------------------------------------------
module paxos_proposer_round_control import ppr_pkg::*; #(
   parameter int PEERS_MAX = PEERS_MAX_DEF
) (
   input  logic          clock,
   input  logic          reset,
   // event channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,   // mode
   // reply_ok[0], reply_status[2:1], higher_proposal[33:3],
   // pending_proposal[65:34], pending_value[97:66], submit_value[129:98]
   input  logic [135:0]  req_tdata,
   // result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [1:0]    rsp_tuser,   // request_kind
   // proposal_number[31:0], request_value[63:32], agreed[64]
   output logic [71:0]   rsp_tdata,
   // register port
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   cfg_type cfg_ff;
   logic    csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peer_count  <= 4'd3;
         cfg_ff.retry_limit <= 8'd3;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_PEER_COUNT) begin
            cfg_ff.peer_count <= csr_pwdata[3:0];
         end else begin
            cfg_ff.retry_limit <= csr_pwdata[7:0];
         end
      end
   end

   // register reads
   assign csr_prdata = (csr_paddr[2] == REG_RETRY_LIMIT) ?
                       {24'b0, cfg_ff.retry_limit} : {28'b0, cfg_ff.peer_count};

   ppr_core #(
      .PEERS_MAX (PEERS_MAX)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ hdl/ppr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_core
// Round engine: applies one event per cycle, unless a result is held on rsp,
// to the proposer state and registers the request or finish result it causes.
// ----------------------------------------------------------------------------
module ppr_core import ppr_pkg::*; #(
   parameter int PEERS_MAX = PEERS_MAX_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,   // mode
   // reply_ok, reply_status, higher_proposal, pending_proposal,
   // pending_value, submit_value, zero fill
   input  logic [135:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [1:0]    rsp_tuser,   // request_kind
   // proposal_number, request_value, agreed, zero fill
   output logic [71:0]   rsp_tdata
);

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PROPOSE = 2'd1,
      PH_ACCEPT  = 2'd2
   } phase_type;

   localparam logic [CNT_W-1:0] PEERS_TOP = CNT_W'(PEERS_MAX);
   localparam logic [CNT_W-1:0] CNT_TOP   = {CNT_W{1'b1}};

   // input field split
   logic                     in_ok;
   logic [1:0]               in_status;
   logic [NUM_W-1:0]         in_higher;
   logic signed [31:0]       in_pnum;
   logic [31:0]              in_pval;
   logic [31:0]              in_sval;
   logic                     in_xfer;

   assign in_ok     = req_tdata[0];
   assign in_status = req_tdata[2:1];
   assign in_higher = req_tdata[33:3];
   assign in_pnum   = $signed(req_tdata[65:34]);
   assign in_pval   = req_tdata[97:66];
   assign in_sval   = req_tdata[129:98];

   // state
   phase_type                phase_ff, phase_in;
   logic [NUM_W-1:0]         highest_ff, highest_in;
   logic [TRY_W-1:0]         tries_ff, tries_in;
   logic [NUM_W-1:0]         own_num_ff, own_num_in;
   logic [31:0]              own_val_ff, own_val_in;
   logic [CNT_W-1:0]         replies_ff, replies_in;
   logic [CNT_W-1:0]         answers_ff, answers_in;
   logic                     higher_ff, higher_in;
   logic                     replay_ff, replay_in;
   logic signed [31:0]       best_num_ff, best_num_in;
   logic [31:0]              best_val_ff, best_val_in;
   logic                     reject_ff, reject_in;

   // result register
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_kind_ff;
   logic [31:0]              rsp_num_ff;
   logic [31:0]              rsp_val_ff;
   logic                     rsp_agreed_ff;

   // combinational step outputs
   logic                     emit;
   logic [1:0]               emit_kind;
   logic [31:0]              emit_num;
   logic [31:0]              emit_val;
   logic                     emit_agreed;
   logic [CNT_W-1:0]         peers;
   logic                     do_try;
   logic                     closed;
   logic                     major;

   // effective peer count, clamped to 1..PEERS_MAX
   always_comb begin
      peers = cfg.peer_count;
      if (peers == '0) begin
         peers = CNT_W'(1);
      end
      if (peers > PEERS_TOP) begin
         peers = PEERS_TOP;
      end
   end

   // one event step
   always_comb begin
      phase_in    = phase_ff;
      highest_in  = highest_ff;
      tries_in    = tries_ff;
      own_num_in  = own_num_ff;
      own_val_in  = own_val_ff;
      replies_in  = replies_ff;
      answers_in  = answers_ff;
      higher_in   = higher_ff;
      replay_in   = replay_ff;
      best_num_in = best_num_ff;
      best_val_in = best_val_ff;
      reject_in   = reject_ff;
      emit        = 1'b0;
      emit_kind   = KIND_PROPOSE;
      emit_num    = '0;
      emit_val    = '0;
      emit_agreed = 1'b0;
      do_try      = 1'b0;
      closed      = 1'b0;
      major       = 1'b0;

      case (mode_type'(req_tuser))
         MODE_REPORT: begin
            if (phase_ff == PH_IDLE && in_higher > highest_ff) begin
               highest_in = in_higher;
            end
         end
         MODE_SUBMIT: begin
            if (phase_ff == PH_IDLE) begin
               own_val_in = in_sval;
               tries_in   = '0;
               do_try     = 1'b1;
            end
         end
         MODE_PROPOSE: begin
            if (phase_ff == PH_PROPOSE) begin
               if (replies_ff != CNT_TOP) begin
                  replies_in = replies_ff + CNT_W'(1);
               end
               if (in_ok) begin
                  if (answers_ff != CNT_TOP) begin
                     answers_in = answers_ff + CNT_W'(1);
                  end
                  if (!higher_ff) begin
                     if (in_status == ST_HIGHER) begin
                        higher_in = 1'b1;
                        if (highest_ff < in_higher) begin
                           highest_in = in_higher;
                        end
                     end else if (in_status != ST_PROMISE) begin
                        if (in_pnum > best_num_ff) begin
                           best_num_in = in_pnum;
                           best_val_in = in_pval;
                        end
                        replay_in = 1'b1;
                     end
                  end
               end
               closed = !(replies_in < peers);
               major  = answers_in > (peers >> 1);
               if (closed) begin
                  if (!major) begin
                     highest_in = own_num_ff;
                     do_try     = 1'b1;
                  end else if (higher_in) begin
                     do_try = 1'b1;
                  end else begin
                     // no pending transaction: propose our own value
                     if (best_num_in == -32'sd1) begin
                        best_num_in = $signed({1'b0, own_num_ff});
                        best_val_in = own_val_ff;
                     end
                     replies_in = '0;
                     answers_in = '0;
                     reject_in  = 1'b0;
                     phase_in   = PH_ACCEPT;
                     emit       = 1'b1;
                     emit_kind  = KIND_ACCEPT;
                     emit_num   = best_num_in;
                     emit_val   = best_val_in;
                  end
               end
            end
         end
         MODE_ACCEPT: begin
            if (phase_ff == PH_ACCEPT) begin
               if (replies_ff != CNT_TOP) begin
                  replies_in = replies_ff + CNT_W'(1);
               end
               if (in_ok) begin
                  if (answers_ff != CNT_TOP) begin
                     answers_in = answers_ff + CNT_W'(1);
                  end
                  if (in_status == ST_REJECT) begin
                     reject_in = 1'b1;
                  end
               end
               closed = !(replies_in < peers);
               major  = answers_in > (peers >> 1);
               if (closed) begin
                  if (!replay_ff && major && !reject_in &&
                      best_num_ff == $signed({1'b0, own_num_ff})) begin
                     phase_in    = PH_IDLE;
                     emit        = 1'b1;
                     emit_kind   = KIND_DONE;
                     emit_agreed = 1'b1;
                  end else begin
                     do_try = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // next try, or give up once the retry budget is spent
      if (do_try) begin
         emit = 1'b1;
         if (tries_in < ({1'b0, cfg.retry_limit} + TRY_W'(1))) begin
            tries_in = tries_in + TRY_W'(1);
            if (highest_in < NUM_TOP) begin
               highest_in = highest_in + NUM_W'(1);
            end
            own_num_in  = highest_in;
            replies_in  = '0;
            answers_in  = '0;
            higher_in   = 1'b0;
            replay_in   = 1'b0;
            reject_in   = 1'b0;
            best_num_in = -32'sd1;
            phase_in    = PH_PROPOSE;
            emit_kind   = KIND_PROPOSE;
            emit_num    = {1'b0, highest_in};
         end else begin
            phase_in  = PH_IDLE;
            emit_kind = KIND_DONE;
         end
      end
   end

   // take a new event whenever the result slot is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign in_xfer    = req_tvalid && req_tready;

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         highest_ff   <= '0;
         tries_ff     <= '0;
         own_num_ff   <= '0;
         replies_ff   <= '0;
         answers_ff   <= '0;
         higher_ff    <= 1'b0;
         replay_ff    <= 1'b0;
         best_num_ff  <= -32'sd1;
         reject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_xfer) begin
            phase_ff     <= phase_in;
            highest_ff   <= highest_in;
            tries_ff     <= tries_in;
            own_num_ff   <= own_num_in;
            replies_ff   <= replies_in;
            answers_ff   <= answers_in;
            higher_ff    <= higher_in;
            replay_ff    <= replay_in;
            best_num_ff  <= best_num_in;
            reject_ff    <= reject_in;
            // slot is free or draining here
            rsp_valid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // value stores and result payload carry no reset
   always_ff @(posedge clock) begin
      if (in_xfer) begin
         own_val_ff  <= own_val_in;
         best_val_ff <= best_val_in;
         if (emit) begin
            rsp_kind_ff   <= emit_kind;
            rsp_num_ff    <= emit_num;
            rsp_val_ff    <= emit_val;
            rsp_agreed_ff <= emit_agreed;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {7'b0, rsp_agreed_ff, rsp_val_ff, rsp_num_ff};

endmodule

@@ bench/paxos_proposer_round_control_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paxos_proposer_round_control_test
// Self-checking bench for the Paxos proposer round control. A tracker class
// follows the proposer state for every event transfer, predicts the propose,
// accept or finish request that the event causes, and matches each result
// transfer against the oldest prediction. A short directed run opens; random
// well-formed rounds with some noise follow over several register settings,
// with bursty event traffic, result back-pressure and a long result hold-off.
// ----------------------------------------------------------------------------
module paxos_proposer_round_control_test;
   import ppr_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_EVENTS = 250;

   // status codes the package leaves unnamed
   localparam logic [1:0] ST_ACCEPTED = ST_PROMISE;
   localparam logic [1:0] ST_PENDING  = 2'd2;
   localparam logic [1:0] ST_UNKNOWN  = 2'd3;

   // register addresses
   localparam logic [2:0] ADDR_PEER_COUNT  = {REG_PEER_COUNT, 2'b00};
   localparam logic [2:0] ADDR_RETRY_LIMIT = {REG_RETRY_LIMIT, 2'b00};

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PROPOSE = 2'd1,
      PH_ACCEPT  = 2'd2
   } round_phase;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] number;
      logic [31:0] value;
      logic        agreed;
   } request_item;

   // tracks the proposer and holds the requests it still owes
   class round_tracker;
      logic [3:0]  peer_count;
      logic [7:0]  retry_limit;
      logic [30:0] highest_seen;
      int unsigned tries_used;
      round_phase  phase;
      logic [30:0] own_proposal;
      logic [31:0] own_value;
      int unsigned replies_seen;
      int unsigned answers_counted;
      bit          higher_found;
      bit          replaying;
      bit          reject_seen;
      int          best_number;
      logic [31:0] best_value;
      request_item outgoing[$];
      int          mismatches;

      function void reset_state();
         peer_count   = 4'd3;
         retry_limit  = 8'd3;
         highest_seen = '0;
         tries_used   = 0;
         phase        = PH_IDLE;
         own_proposal = '0;
         own_value    = '0;
         outgoing.delete();
         clear_tally();
      endfunction

      function void set_reg(logic [2:0] addr, logic [31:0] data);
         if (addr == ADDR_PEER_COUNT) peer_count = data[3:0];
         else if (addr == ADDR_RETRY_LIMIT) retry_limit = data[7:0];
      endfunction

      function void clear_tally();
         replies_seen    = 0;
         answers_counted = 0;
         higher_found    = 1'b0;
         replaying       = 1'b0;
         reject_seen     = 1'b0;
         best_number     = -1;
         best_value      = '0;
      endfunction

      // peer count as the round engine sees it
      function int unsigned active_peers();
         if (peer_count == 4'd0) return 1;
         if (peer_count > PEERS_MAX_DEF) return PEERS_MAX_DEF;
         return peer_count;
      endfunction

      function bit majority();
         return answers_counted > active_peers() / 2;
      endfunction

      function void queue_result(logic [1:0] kind, logic [31:0] number, logic [31:0] value,
                                 logic agreed);
         request_item r;
         r.kind   = kind;
         r.number = number;
         r.value  = value;
         r.agreed = agreed;
         outgoing.insert(outgoing.size(), r);
      endfunction

      // start a new try, or finish the submit when tries are used up
      function void next_try();
         if (tries_used < retry_limit + 1) begin
            tries_used++;
            if (highest_seen != NUM_TOP) highest_seen = highest_seen + 1'b1;
            own_proposal = highest_seen;
            clear_tally();
            phase = PH_PROPOSE;
            queue_result(KIND_PROPOSE, {1'b0, own_proposal}, '0, 1'b0);
         end else begin
            phase = PH_IDLE;
            queue_result(KIND_DONE, '0, '0, 1'b0);
         end
      endfunction

      // returns 1 when the event is taken in the current phase
      function bit apply_event(mode_type mode, bit ok, logic [1:0] st, logic [30:0] higher,
                               logic [31:0] pnum_bits, logic [31:0] pval, logic [31:0] sval);
         int pnum;
         pnum = pnum_bits;
         case (mode)
            MODE_REPORT: begin
               if (phase != PH_IDLE) return 1'b0;
               if (higher > highest_seen) highest_seen = higher;
               return 1'b1;
            end
            MODE_SUBMIT: begin
               if (phase != PH_IDLE) return 1'b0;
               own_value  = sval;
               tries_used = 0;
               next_try();
               return 1'b1;
            end
            MODE_PROPOSE: begin
               if (phase != PH_PROPOSE) return 1'b0;
               if (replies_seen < 15) replies_seen++;
               if (ok) begin
                  if (answers_counted < 15) answers_counted++;
                  // only the first higher promise counts; pendings after it are dropped
                  if (!higher_found) begin
                     if (st == ST_HIGHER) begin
                        higher_found = 1'b1;
                        if (highest_seen < higher) highest_seen = higher;
                     end else if (st != ST_PROMISE) begin
                        if (pnum > best_number) begin
                           best_number = pnum;
                           best_value  = pval;
                        end
                        replaying = 1'b1;
                     end
                  end
               end
               if (replies_seen < active_peers()) return 1'b1;
               if (!majority()) begin
                  highest_seen = own_proposal;
                  next_try();
                  return 1'b1;
               end
               if (higher_found) begin
                  next_try();
                  return 1'b1;
               end
               if (best_number == -1) begin
                  best_number = int'({1'b0, own_proposal});
                  best_value  = own_value;
               end
               replies_seen    = 0;
               answers_counted = 0;
               reject_seen     = 1'b0;
               phase           = PH_ACCEPT;
               queue_result(KIND_ACCEPT, best_number, best_value, 1'b0);
               return 1'b1;
            end
            default: begin
               if (phase != PH_ACCEPT) return 1'b0;
               if (replies_seen < 15) replies_seen++;
               if (ok) begin
                  if (answers_counted < 15) answers_counted++;
                  if (st == ST_REJECT) reject_seen = 1'b1;
               end
               if (replies_seen < active_peers()) return 1'b1;
               if (!replaying && majority() && !reject_seen &&
                   best_number == int'({1'b0, own_proposal})) begin
                  phase = PH_IDLE;
                  queue_result(KIND_DONE, '0, '0, 1'b1);
               end else begin
                  next_try();
               end
               return 1'b1;
            end
         endcase
      endfunction

      function void match_request(logic [1:0] kind, logic [71:0] data);
         request_item want;
         if (outgoing.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d number %h value %h agreed %0d",
                        kind, data[31:0], data[63:32], data[64]);
            return;
         end
         want = outgoing.pop_front();
         if (kind !== want.kind || data[31:0] !== want.number ||
             data[63:32] !== want.value || data[64] !== want.agreed) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"result mismatch: kind %0d/%0d number %h/%h value %h/%h ",
                         "agreed %0d/%0d (expected/actual)"},
                        want.kind, kind, want.number, data[31:0], want.value, data[63:32],
                        want.agreed, data[64]);
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [1:0]    req_tuser;   // mode
   // reply_ok[0], reply_status[2:1], higher_proposal[33:3],
   // pending_proposal[65:34], pending_value[97:66], submit_value[129:98]
   logic [135:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [1:0]    rsp_tuser;   // request_kind
   // proposal_number[31:0], request_value[63:32], agreed[64]
   logic [71:0]   rsp_tdata;
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [2:0]    csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   round_tracker tracker = new;
   bit           took_effect;
   bit           hold_off;
   int           rx_style;

   paxos_proposer_round_control u_top (.*);

   // clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // run limit
   initial begin
      #4_000_000;
      $display("paxos_proposer_round_control_test NOT OK");
      $finish;
   end

   // result receiver: stall pattern per phase, plus one long hold-off on request
   initial begin
      int cyc;
      cyc = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            case (rx_style)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 99) < 70);
               2:       rsp_tready <= ((cyc % 9) > 2);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // result monitor
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            tracker.match_request(rsp_tuser, rsp_tdata);
      end
   end

   // offer one event and wait for its transfer
   task automatic send_event(input mode_type mode, input bit ok, input logic [1:0] st,
                             input logic [30:0] higher, input logic [31:0] pnum,
                             input logic [31:0] pval, input logic [31:0] sval);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'b0, sval, pval, pnum, higher, st, ok};
      do @(posedge clock); while (!req_tready);
      took_effect = tracker.apply_event(mode, ok, st, higher, pnum, pval, sval);
   endtask

   // register write: setup, access, then idle
   task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      tracker.set_reg(addr, data);
      @(posedge clock);
   endtask

   // stop sending and let every owed request come out
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.outgoing.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [30:0] pick_higher();
      logic [30:0] h;
      case ($urandom_range(0, 9))
         0:       h = 31'($urandom);
         1, 2:    h = 31'($urandom_range(0, 100));
         3:       h = 31'(tracker.highest_seen - $urandom_range(0, 3));
         default: h = 31'(tracker.highest_seen + $urandom_range(0, 40));
      endcase
      return h;
   endfunction

   function automatic logic [31:0] pick_pending();
      logic [31:0] p;
      case ($urandom_range(0, 6))
         0:       p = 32'hFFFF_FFFF;
         1, 2:    p = $urandom;
         3:       p = 32'h7FFF_FFFF;
         4:       p = $urandom_range(0, 64);
         default: p = {1'b0, tracker.own_proposal} + $urandom_range(0, 4) - 2;
      endcase
      return p;
   endfunction

   // one random event, mostly what the current round waits for
   task automatic random_event();
      int          pick;
      mode_type    mode;
      logic [1:0]  st;
      pick = $urandom_range(0, 99);
      case (tracker.phase)
         PH_IDLE:    mode = (pick < 70) ? MODE_SUBMIT : (pick < 88) ? MODE_REPORT :
                            mode_type'($urandom_range(0, 3));
         PH_PROPOSE: mode = (pick < 92) ? MODE_PROPOSE : mode_type'($urandom_range(0, 3));
         default:    mode = (pick < 92) ? MODE_ACCEPT : mode_type'($urandom_range(0, 3));
      endcase
      pick = $urandom_range(0, 99);
      if (mode == MODE_PROPOSE)
         st = (pick < 70) ? ST_PROMISE : (pick < 82) ? ST_HIGHER :
              (pick < 94) ? ST_PENDING : ST_UNKNOWN;
      else if (mode == MODE_ACCEPT)
         st = (pick < 85) ? ST_ACCEPTED : (pick < 95) ? ST_REJECT :
              (pick < 98) ? ST_PENDING : ST_UNKNOWN;
      else
         st = 2'($urandom_range(0, 3));
      send_event(mode, $urandom_range(0, 99) < 85, st, pick_higher(), pick_pending(),
                 $urandom, $urandom);
   endtask

   // one random phase under a given setting
   task automatic run_phase(input logic [3:0] peers, input logic [7:0] retries,
                            input int style, input bit gaps_on, input bit long_hold,
                            input bit mid_pause);
      int taken;
      int burst;
      drain();
      write_reg(ADDR_PEER_COUNT, {28'd0, peers});
      write_reg(ADDR_RETRY_LIMIT, {24'd0, retries});
      rx_style = style;
      if (long_hold) hold_off = 1'b1;
      taken = 0;
      burst = $urandom_range(1, 24);
      while (taken < PHASE_EVENTS) begin
         random_event();
         if (took_effect) taken++;
         if (mid_pause && took_effect && taken == PHASE_EVENTS / 2) begin
            drain();
         end else if (gaps_on) begin
            burst--;
            if (burst == 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
               burst = $urandom_range(1, 24);
            end
         end
      end
   endtask

   // main sequence
   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tuser   <= '0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      hold_off    = 1'b0;
      rx_style    = 1;
      tracker.reset_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed run on the reset setting: three peers, three retries
      send_event(MODE_REPORT, 1'b1, ST_PROMISE, 31'd5, '0, '0, '0);
      send_event(MODE_REPORT, 1'b1, ST_PROMISE, 31'd2, '0, '0, '0);
      send_event(MODE_PROPOSE, 1'b1, ST_PROMISE, '0, '0, '0, '0);
      send_event(MODE_ACCEPT, 1'b1, ST_ACCEPTED, '0, '0, '0, '0);
      send_event(MODE_SUBMIT, 1'b1, ST_PROMISE, '0, '0, '0, 32'hFFFF_FFFF);
      send_event(MODE_SUBMIT, 1'b1, ST_PROMISE, '0, '0, '0, 32'h1234_5678);
      send_event(MODE_REPORT, 1'b1, ST_PROMISE, 31'd900, '0, '0, '0);
      // clean round: two promises and one failed call
      send_event(MODE_PROPOSE, 1'b1, ST_PROMISE, '0, '0, '0, '0);
      send_event(MODE_PROPOSE, 1'b1, ST_PROMISE, NUM_TOP, 32'h8000_0000, '1, '0);
      send_event(MODE_PROPOSE, 1'b0, ST_HIGHER, NUM_TOP, '0, '0, '0);
      // odd accept status is no rejection; a failed call's status is ignored
      send_event(MODE_ACCEPT, 1'b1, ST_UNKNOWN, '0, '0, '0, '0);
      send_event(MODE_ACCEPT, 1'b1, ST_ACCEPTED, '0, '0, '0, '0);
      send_event(MODE_ACCEPT, 1'b0, ST_REJECT, '0, '0, '0, '0);
      // pending then higher promise; a pending after it is dropped
      send_event(MODE_SUBMIT, 1'b1, ST_PROMISE, '0, '0, '0, '0);
      send_event(MODE_PROPOSE, 1'b1, ST_PENDING, '0, 32'd100, 32'hAAAA_AAAA, '0);
      send_event(MODE_PROPOSE, 1'b1, ST_HIGHER, 31'd50, '0, '0, '0);
      send_event(MODE_PROPOSE, 1'b1, ST_PENDING, '0, 32'd200, 32'h5555_5555, '0);
      // pending numbers at and below minus one are never best; replay of own value
      send_event(MODE_PROPOSE, 1'b1, ST_UNKNOWN, '0, -32'sd5, 32'h1111_1111, '0);
      send_event(MODE_PROPOSE, 1'b1, ST_PENDING, '0, 32'hFFFF_FFFF, 32'h2222_2222, '0);
      send_event(MODE_PROPOSE, 1'b0, ST_PROMISE, '0, '0, '0, '0);
      send_event(MODE_ACCEPT, 1'b1, ST_ACCEPTED, '0, '0, '0, '0);
      send_event(MODE_ACCEPT, 1'b1, ST_ACCEPTED, '0, '0, '0, '0);
      send_event(MODE_ACCEPT, 1'b1, ST_ACCEPTED, '0, '0, '0, '0);
      // no majority twice: the last try runs out
      repeat (3) send_event(MODE_PROPOSE, 1'b0, ST_PROMISE, '0, '0, '0, '0);
      send_event(MODE_PROPOSE, 1'b1, ST_PROMISE, '0, '0, '0, '0);
      repeat (2) send_event(MODE_PROPOSE, 1'b0, ST_PROMISE, '0, '0, '0, '0);

      // random phases over several settings, extremes included
      run_phase(4'd1, 8'd0, 0, 1'b0, 1'b0, 1'b0);
      run_phase(4'd8, 8'd255, 1, 1'b1, 1'b0, 1'b0);
      run_phase(4'd3, 8'd3, 0, 1'b1, 1'b1, 1'b0);
      run_phase(4'd15, 8'd1, 2, 1'b1, 1'b0, 1'b0);
      run_phase(4'd0, 8'd5, 3, 1'b1, 1'b0, 1'b1);
      run_phase(4'd5, 8'd2, 1, 1'b0, 1'b0, 1'b0);
      run_phase(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), $urandom_range(0, 3),
                1'b1, 1'b0, 1'b0);
      run_phase(4'd4, 8'd7, 2, 1'b1, 1'b0, 1'b0);

      // proposal numbers at the top: close any open submit, then saturate
      drain();
      write_reg(ADDR_PEER_COUNT, 32'd1);
      write_reg(ADDR_RETRY_LIMIT, 32'd1);
      rx_style = 1;
      while (tracker.phase != PH_IDLE)
         send_event((tracker.phase == PH_PROPOSE) ? MODE_PROPOSE : MODE_ACCEPT, 1'b0,
                    ST_PROMISE, '0, '0, '0, '0);
      send_event(MODE_REPORT, 1'b1, ST_PROMISE, NUM_TOP - 1'b1, '0, '0, '0);
      send_event(MODE_SUBMIT, 1'b1, ST_PROMISE, '0, '0, '0, 32'hC0DE_0001);
      send_event(MODE_PROPOSE, 1'b1, ST_HIGHER, NUM_TOP, '0, '0, '0);
      send_event(MODE_PROPOSE, 1'b1, ST_PROMISE, '0, '0, '0, '0);
      send_event(MODE_ACCEPT, 1'b1, ST_ACCEPTED, '0, '0, '0, '0);

      drain();
      if (tracker.mismatches == 0 && tracker.outgoing.size() == 0)
         $display("paxos_proposer_round_control_test OK");
      else
         $display("paxos_proposer_round_control_test NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
hdl/ppr_pkg.sv
hdl/ppr_core.sv
hdl/paxos_proposer_round_control.sv
bench/paxos_proposer_round_control_test.sv
